>>> hdl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and the gain sine table of the space vector PWM
// compare generator: control word layout, datapath select codes, Q formats.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // fixed point formats
  localparam int SINE_BITS  = 16;
  localparam int DUTY_SHIFT = SINE_BITS + 1;
  localparam int DAC_MAX    = 4095;
  localparam logic [16:0] ONE  = 17'(1 << SINE_BITS);
  localparam logic [17:0] FULL = 18'(2 << SINE_BITS);

  // angle constants in degrees
  localparam logic [8:0] DEG_LAST   = 9'd359;
  localparam logic [9:0] DEG_FULL   = 10'd360;
  localparam logic [9:0] DEG_OFFSET = 10'd270;
  localparam logic [5:0] DEG_SECTOR = 6'd60;

  // sector numbers
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;

  // configuration register indexes
  localparam logic CFG_MOD_INDEX = 1'b0;
  localparam logic CFG_PERIOD    = 1'b1;
  localparam logic [15:0] MI_RESET     = 16'd32768;
  localparam logic [15:0] PERIOD_RESET = 16'd16800;

  // program addresses used as jump targets
  localparam logic [3:0] STEP_IDLE     = 4'd0;
  localparam logic [3:0] STEP_WAIT_OUT = 4'd13;

  // sine argument scale and sqrt3/2, both Q30
  localparam longint unsigned DEG_Q30        = 64'd18740330;
  localparam longint unsigned HALF_SQRT3_Q30 = 64'd929887697;

  typedef enum logic [1:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ITEM,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    A_MI,
    A_DUTY_A,
    A_DUTY_B,
    A_DUTY_C
  } mul_a_e;

  typedef enum logic [1:0] {
    B_GAIN_T1,
    B_GAIN_T2,
    B_PERIOD,
    B_DAC
  } mul_b_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_F1,
    WB_F2,
    WB_CMP_A,
    WB_CMP_B,
    WB_CMP_C,
    WB_DAC_A,
    WB_DAC_B
  } wb_e;

  // one microcode word
  typedef struct packed {
    cond_e      cond;
    logic [3:0] target;
    logic       accept;
    logic       ld_geo;
    logic       ld_zero;
    logic       ld_duty;
    mul_a_e     a_sel;
    mul_b_e     b_sel;
    wb_e        wb;
    logic       emit;
  } ucw_t;

  // condition flags from the datapath to the sequencer
  typedef struct packed {
    logic item;
    logic out_busy;
  } flags_t;

  typedef logic [15:0] gain_tbl_t [0:60];

  // sqrt3/2 * sin(deg) in Q16, sine from a Taylor series in Q30
  function automatic logic [15:0] gain_calc(int unsigned deg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned g;
    longint          sum;
    x    = longint'(deg) * DEG_Q30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    g = (longint'(sum) * HALF_SQRT3_Q30 + (64'd1 << 29)) >> 30;
    g = (g + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
    return g[15:0];
  endfunction

  function automatic gain_tbl_t gain_build();
    gain_tbl_t t;
    for (int unsigned d = 0; d <= 60; d++) begin
      t[d] = gain_calc(d);
    end
    return t;
  endfunction

  localparam gain_tbl_t GAIN_TBL = gain_build();

endpackage

>>> hdl/svpwm_ucode_rom.sv
// ----------------------------------------------------------------------------
// svpwm_ucode_rom
// Control store: one microcode word per program step.
// ----------------------------------------------------------------------------
module svpwm_ucode_rom (
  input  logic [3:0]      step_i,
  output svpwm_pkg::ucw_t ucw_o
);

  svpwm_pkg::ucw_t w;

  // program: geometry, two gain products, zero time, duties, five scalings
  always_comb begin
    w        = '0;
    w.cond   = svpwm_pkg::C_NEXT;
    w.target = svpwm_pkg::STEP_IDLE;
    w.a_sel  = svpwm_pkg::A_MI;
    w.b_sel  = svpwm_pkg::B_GAIN_T1;
    w.wb     = svpwm_pkg::WB_NONE;
    case (step_i)
      4'd0: begin
        w.accept = 1'b1;
        w.cond   = svpwm_pkg::C_NO_ITEM;
        w.target = svpwm_pkg::STEP_IDLE;
      end
      4'd1: begin
        w.ld_geo = 1'b1;
      end
      4'd2: begin
        w.a_sel = svpwm_pkg::A_MI;
        w.b_sel = svpwm_pkg::B_GAIN_T1;
      end
      4'd3: begin
        w.a_sel = svpwm_pkg::A_MI;
        w.b_sel = svpwm_pkg::B_GAIN_T2;
        w.wb    = svpwm_pkg::WB_F1;
      end
      4'd4: begin
        w.wb = svpwm_pkg::WB_F2;
      end
      4'd5: begin
        w.ld_zero = 1'b1;
      end
      4'd6: begin
        w.ld_duty = 1'b1;
      end
      4'd7: begin
        w.a_sel = svpwm_pkg::A_DUTY_A;
        w.b_sel = svpwm_pkg::B_PERIOD;
      end
      4'd8: begin
        w.a_sel = svpwm_pkg::A_DUTY_B;
        w.b_sel = svpwm_pkg::B_PERIOD;
        w.wb    = svpwm_pkg::WB_CMP_A;
      end
      4'd9: begin
        w.a_sel = svpwm_pkg::A_DUTY_C;
        w.b_sel = svpwm_pkg::B_PERIOD;
        w.wb    = svpwm_pkg::WB_CMP_B;
      end
      4'd10: begin
        w.a_sel = svpwm_pkg::A_DUTY_A;
        w.b_sel = svpwm_pkg::B_DAC;
        w.wb    = svpwm_pkg::WB_CMP_C;
      end
      4'd11: begin
        w.a_sel = svpwm_pkg::A_DUTY_B;
        w.b_sel = svpwm_pkg::B_DAC;
        w.wb    = svpwm_pkg::WB_DAC_A;
      end
      4'd12: begin
        w.wb = svpwm_pkg::WB_DAC_B;
      end
      4'd13: begin
        w.cond   = svpwm_pkg::C_OUT_BUSY;
        w.target = svpwm_pkg::STEP_WAIT_OUT;
      end
      4'd14: begin
        w.emit   = 1'b1;
        w.cond   = svpwm_pkg::C_ALWAYS;
        w.target = svpwm_pkg::STEP_IDLE;
      end
      default: begin
        w.cond   = svpwm_pkg::C_ALWAYS;
        w.target = svpwm_pkg::STEP_IDLE;
      end
    endcase
  end

  assign ucw_o = w;

endmodule

>>> hdl/svpwm_seq.sv
// ----------------------------------------------------------------------------
// svpwm_seq
// Step counter with conditional jumps taken from the microcode word.
// ----------------------------------------------------------------------------
module svpwm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svpwm_pkg::ucw_t   ucw_i,
  input  svpwm_pkg::flags_t flags_i,
  output logic [3:0]        step_o
);

  logic [3:0] step_q;
  logic [3:0] step_d;
  logic       take;

  // jump condition
  always_comb begin
    case (ucw_i.cond)
      svpwm_pkg::C_ALWAYS:   take = 1'b1;
      svpwm_pkg::C_NO_ITEM:  take = ~flags_i.item;
      svpwm_pkg::C_OUT_BUSY: take = flags_i.out_busy;
      default:               take = 1'b0;
    endcase
    step_d = take ? ucw_i.target : step_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= svpwm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

>>> hdl/svpwm_datapath.sv
// ----------------------------------------------------------------------------
// svpwm_datapath
// Angle and sector logic, shared multiplier, dwell and duty registers,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module svpwm_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svpwm_pkg::ucw_t   ucw_i,
  input  logic              in_fire_i,
  input  logic              tick_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              out_stall_i,
  output svpwm_pkg::flags_t flags_o,
  output logic              out_valid_o,
  output logic [15:0]       compare_a_o,
  output logic [15:0]       compare_b_o,
  output logic [15:0]       compare_c_o,
  output logic [11:0]       dac_a_o,
  output logic [11:0]       dac_b_o,
  output logic [2:0]        sector_out_o,
  output logic [8:0]        angle_out_o
);

  logic [15:0] mi_q;
  logic [15:0] period_q;
  logic [8:0]  theta_q;
  logic [2:0]  sector_q;
  logic [5:0]  r_q;
  logic [33:0] prod_q;
  logic [17:0] f1_q;
  logic [17:0] f2_q;
  logic [16:0] h_q;
  logic [17:0] duty_a_q;
  logic [17:0] duty_b_q;
  logic [17:0] duty_c_q;
  logic [15:0] cmp_a_q;
  logic [15:0] cmp_b_q;
  logic [15:0] cmp_c_q;
  logic [11:0] dac_a_q;
  logic [11:0] dac_b_q;
  logic        out_valid_q;

  logic [9:0]  alpha_sum;
  logic [8:0]  alpha;
  logic [2:0]  sector_d;
  logic [8:0]  r_wide;
  logic [5:0]  t1_idx;
  logic [17:0] mul_a;
  logic [15:0] mul_b;
  logic [33:0] f_round;
  logic signed [19:0] f0_s;
  logic signed [20:0] t1_s;
  logic signed [20:0] t2_s;
  logic signed [20:0] h_s;
  logic signed [20:0] act_s;
  logic signed [20:0] lead_s;
  logic signed [20:0] lag_s;
  logic signed [20:0] da_s;
  logic signed [20:0] db_s;
  logic signed [20:0] dc_s;

  // clamp a duty to the range zero to one full period
  function automatic logic [17:0] clamp_duty(logic signed [20:0] d);
    logic [17:0] res;
    if (d < 0) begin
      res = '0;
    end else if (d > $signed({3'b000, svpwm_pkg::FULL})) begin
      res = svpwm_pkg::FULL;
    end else begin
      res = d[17:0];
    end
    return res;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mi_q     <= svpwm_pkg::MI_RESET;
      period_q <= svpwm_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == svpwm_pkg::CFG_MOD_INDEX) begin
        mi_q <= cfg_data_i;
      end else begin
        period_q <= cfg_data_i;
      end
    end
  end

  // reference angle, advanced on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q <= '0;
    end else if (in_fire_i && tick_i) begin
      theta_q <= (theta_q == svpwm_pkg::DEG_LAST) ? 9'd0 : theta_q + 9'd1;
    end
  end

  // space angle, sector and angle within the sector
  always_comb begin
    alpha_sum = {1'b0, theta_q} + svpwm_pkg::DEG_OFFSET;
    alpha     = (alpha_sum >= svpwm_pkg::DEG_FULL) ?
                9'(alpha_sum - svpwm_pkg::DEG_FULL) : alpha_sum[8:0];
    if (alpha >= 9'd300) begin
      sector_d = svpwm_pkg::SEC_6;
      r_wide   = alpha - 9'd300;
    end else if (alpha >= 9'd240) begin
      sector_d = svpwm_pkg::SEC_5;
      r_wide   = alpha - 9'd240;
    end else if (alpha >= 9'd180) begin
      sector_d = svpwm_pkg::SEC_4;
      r_wide   = alpha - 9'd180;
    end else if (alpha >= 9'd120) begin
      sector_d = svpwm_pkg::SEC_3;
      r_wide   = alpha - 9'd120;
    end else if (alpha >= 9'd60) begin
      sector_d = svpwm_pkg::SEC_2;
      r_wide   = alpha - 9'd60;
    end else begin
      sector_d = svpwm_pkg::SEC_1;
      r_wide   = alpha;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ucw_i.ld_geo) begin
      sector_q <= sector_d;
      r_q      <= r_wide[5:0];
    end
  end

  // shared multiplier operands
  assign t1_idx = svpwm_pkg::DEG_SECTOR - r_q;

  always_comb begin
    case (ucw_i.a_sel)
      svpwm_pkg::A_DUTY_A: mul_a = duty_a_q;
      svpwm_pkg::A_DUTY_B: mul_a = duty_b_q;
      svpwm_pkg::A_DUTY_C: mul_a = duty_c_q;
      default:             mul_a = {2'b00, mi_q};
    endcase
    case (ucw_i.b_sel)
      svpwm_pkg::B_GAIN_T2: mul_b = svpwm_pkg::GAIN_TBL[r_q];
      svpwm_pkg::B_PERIOD:  mul_b = period_q;
      svpwm_pkg::B_DAC:     mul_b = 16'(svpwm_pkg::DAC_MAX);
      default:              mul_b = svpwm_pkg::GAIN_TBL[t1_idx];
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // write back of the previous product
  assign f_round = prod_q + 34'd16384;

  always_ff @(posedge clk_i) begin
    case (ucw_i.wb)
      svpwm_pkg::WB_F1:    f1_q    <= f_round[32:15];
      svpwm_pkg::WB_F2:    f2_q    <= f_round[32:15];
      svpwm_pkg::WB_CMP_A: cmp_a_q <= prod_q[svpwm_pkg::DUTY_SHIFT +: 16];
      svpwm_pkg::WB_CMP_B: cmp_b_q <= prod_q[svpwm_pkg::DUTY_SHIFT +: 16];
      svpwm_pkg::WB_CMP_C: cmp_c_q <= prod_q[svpwm_pkg::DUTY_SHIFT +: 16];
      svpwm_pkg::WB_DAC_A: dac_a_q <= prod_q[svpwm_pkg::DUTY_SHIFT +: 12];
      svpwm_pkg::WB_DAC_B: dac_b_q <= prod_q[svpwm_pkg::DUTY_SHIFT +: 12];
      default: begin
      end
    endcase
  end

  // zero time, saturated at zero under overmodulation
  assign f0_s = $signed({3'b000, svpwm_pkg::ONE}) - $signed({2'b00, f1_q})
              - $signed({2'b00, f2_q});

  always_ff @(posedge clk_i) begin
    if (ucw_i.ld_zero) begin
      h_q <= f0_s[19] ? 17'd0 : f0_s[16:0];
    end
  end

  // six-sector table
  always_comb begin
    t1_s   = $signed({2'b00, f1_q, 1'b0});
    t2_s   = $signed({2'b00, f2_q, 1'b0});
    h_s    = $signed({4'b0000, h_q});
    act_s  = t1_s + t2_s + h_s;
    lead_s = t2_s + h_s;
    lag_s  = $signed({3'b000, svpwm_pkg::FULL}) - lead_s;
    case (sector_q)
      svpwm_pkg::SEC_1: begin da_s = act_s;  db_s = lead_s; dc_s = h_s;    end
      svpwm_pkg::SEC_2: begin da_s = lag_s;  db_s = act_s;  dc_s = h_s;    end
      svpwm_pkg::SEC_3: begin da_s = h_s;    db_s = act_s;  dc_s = lead_s; end
      svpwm_pkg::SEC_4: begin da_s = h_s;    db_s = lag_s;  dc_s = act_s;  end
      svpwm_pkg::SEC_5: begin da_s = lead_s; db_s = h_s;    dc_s = act_s;  end
      default:          begin da_s = act_s;  db_s = h_s;    dc_s = lag_s;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ucw_i.ld_duty) begin
      duty_a_q <= clamp_duty(da_s);
      duty_b_q <= clamp_duty(db_s);
      duty_c_q <= clamp_duty(dc_s);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ucw_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ucw_i.emit) begin
      compare_a_o  <= cmp_a_q;
      compare_b_o  <= cmp_b_q;
      compare_c_o  <= cmp_c_q;
      dac_a_o      <= dac_a_q;
      dac_b_o      <= dac_b_q;
      sector_out_o <= sector_q;
      angle_out_o  <= theta_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flags_o.item     = in_fire_i;
  assign flags_o.out_busy = out_valid_q & out_stall_i;

endmodule

>>> hdl/svpwm_compare_generator.sv
// ----------------------------------------------------------------------------
// svpwm_compare_generator
// Two-level six-sector space vector PWM: per item advances the reference
// angle on tick_i, finds sector and dwell times, emits timer compare counts
// plus monitor DAC values, run by a microcoded sequencer over one multiplier.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  input     in_valid_i, in_stall_o, tick_i           in
//  output    out_valid_o, out_stall_i, compare_*_o,   out
//            dac_a_o, dac_b_o, sector_out_o, angle_out_o
//  config    cfg_we_i, cfg_idx_i, cfg_data_i          in
//
//  an item is taken only at program step zero; the result goes to the output
//  register at the emit step, and the next item can be taken only after
//  that, so one item is in work at a time
//  one shared 18x16 multiplier runs seven products per item; the 15-step
//  program holds at its wait step while the output register still holds
//  an untaken result
//  reset clears the angle to zero, loads the register defaults and drops
//  the output valid; there is no clearing pass
//
module svpwm_compare_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        tick_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] compare_a_o,
  output logic [15:0] compare_b_o,
  output logic [15:0] compare_c_o,
  output logic [11:0] dac_a_o,
  output logic [11:0] dac_b_o,
  output logic [2:0]  sector_out_o,
  output logic [8:0]  angle_out_o
);

  logic [3:0]        step;
  svpwm_pkg::ucw_t   ucw;
  svpwm_pkg::flags_t flags;
  logic              in_fire;

  // item handshake
  assign in_stall_o = ~ucw.accept;
  assign in_fire    = in_valid_i & ucw.accept;

  svpwm_ucode_rom u_rom (
    .step_i (step),
    .ucw_o  (ucw)
  );

  svpwm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ucw_i   (ucw),
    .flags_i (flags),
    .step_o  (step)
  );

  svpwm_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ucw_i        (ucw),
    .in_fire_i    (in_fire),
    .tick_i       (tick_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .flags_o      (flags),
    .out_valid_o  (out_valid_o),
    .compare_a_o  (compare_a_o),
    .compare_b_o  (compare_b_o),
    .compare_c_o  (compare_c_o),
    .dac_a_o      (dac_a_o),
    .dac_b_o      (dac_b_o),
    .sector_out_o (sector_out_o),
    .angle_out_o  (angle_out_o)
  );

  // one item in flight: stall follows every accepted item
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("item accepted while another is in work");

  // a result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucw.emit |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over an untaken result");

  // delivered sector lies in one to six
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sector_out_o != 3'd0 && sector_out_o != 3'd7))
    else $error("sector out of range");

  // delivered angle lies below a full turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_out_o < 9'd360)
    else $error("angle out of range");

endmodule
